@@ sv/knn_top_k_distance_classifier_defines.svh @@
// Assertion macros shared by the k-nearest-neighbour classifier RTL.
`ifndef KNN_TOP_K_DISTANCE_CLASSIFIER_DEFINES_SVH
`define KNN_TOP_K_DISTANCE_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define KNN_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define KNN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/knn_pkg.sv @@
// Types, constants and operation codes of the k-nearest-neighbour classifier.
package knn_pkg;

    localparam int MAX_NEIGHBOURS_DEF = 9;
    localparam int IMAGE_PIXELS_DEF   = 28 * 28;

    localparam int DIST_W  = 26;
    localparam int LABEL_W = 4;
    localparam int PIX_W   = 8;
    localparam int IDX_W   = 10;
    localparam int RANK_W  = 4;
    localparam int CNT_CFG_W = 4;

    localparam logic [DIST_W-1:0]    DIST_MAX     = {DIST_W{1'b1}};
    localparam logic [CNT_CFG_W-1:0] ACTIVE_RESET = 4'd9;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_REF    = 2'd1;
    localparam logic [1:0] OP_REPORT = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    typedef struct packed {
        logic [1:0]         op;
        logic [IDX_W-1:0]   pixel_index;
        logic [PIX_W-1:0]   pixel_value;
        logic [LABEL_W-1:0] ref_label;
        logic               last_pixel;
    } t_request;

    typedef struct packed {
        logic [RANK_W-1:0]  rank;
        logic [DIST_W-1:0]  neighbour_distance;
        logic [LABEL_W-1:0] neighbour_label;
        logic               entry_valid;
        logic               last_entry;
    } t_result;

    // One list slot as held by a chain cell.
    typedef struct packed {
        logic               valid;
        logic [DIST_W-1:0]  distance;
        logic [LABEL_W-1:0] label;
    } t_slot;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic               insert;
        logic               clear;
        logic               rotate;
        logic [DIST_W-1:0]  distance;
        logic [LABEL_W-1:0] label;
    } t_chain_ctrl;

endpackage

@@ sv/knn_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module knn_ram import knn_pkg::*; #(
    parameter int WIDTH = PIX_W,
    parameter int DEPTH = IMAGE_PIXELS_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ sv/knn_cell.sv @@
// One slot of the sorted neighbour chain: insert-shift, rotate and clear.
module knn_cell import knn_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_chain_ctrl i_ctrl,
    input  logic        i_active,
    input  logic        i_wrap,
    input  logic        i_take_prev,
    input  t_slot       i_prev,
    input  t_slot       i_next,
    input  t_slot       i_head,
    output logic        o_take,
    output t_slot       o_slot
);

    logic               r_valid;
    logic [DIST_W-1:0]  r_dist;
    logic [LABEL_W-1:0] r_label;
    logic               w_here;
    t_slot              w_load;
    logic               w_load_en;

    // New entry lands at the first active slot that is empty or strictly farther;
    // every active slot after it takes its left neighbour.
    assign w_here = !r_valid || (i_ctrl.distance < r_dist);
    assign o_take = i_ctrl.insert && i_active && (i_take_prev || w_here);

    always_comb begin
        w_load    = i_next;
        w_load_en = 1'b0;
        priority if (o_take) begin
            w_load_en = 1'b1;
            if (i_take_prev) begin
                w_load = i_prev;
            end else begin
                w_load = '{valid: 1'b1, distance: i_ctrl.distance, label: i_ctrl.label};
            end
        end else if (i_ctrl.rotate && i_active) begin
            w_load_en = 1'b1;
            w_load    = i_wrap ? i_head : i_next;
        end else begin
            w_load_en = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.clear) begin
            r_valid <= 1'b0;
        end else if (w_load_en) begin
            r_valid <= w_load.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.clear) begin
            r_dist  <= '0;
            r_label <= '0;
        end else if (w_load_en) begin
            r_dist  <= w_load.distance;
            r_label <= w_load.label;
        end
    end

    assign o_slot = '{valid: r_valid, distance: r_dist, label: r_label};

endmodule

@@ sv/knn_top_k_distance_classifier.sv @@
// Top level of the k-nearest-neighbour classifier: distance pipeline and neighbour chain.
//
// Input channel (i_in_valid / o_in_stall / i_in_req) carries one request per item:
// load a query pixel, stream a reference pixel, report the list or clear it.
// Load and reference-pixel requests are taken one per cycle while o_in_stall is low.
// A reference pixel goes through query RAM read, square and accumulate; on its last
// pixel the sum passes the stage-1 to stage-3 registers into the sorted chain of cells.
// Clear follows the same three-stage path, so it lands after earlier inserts.
// A report raises o_in_stall until done: it waits for the pipeline to drain, then
// emits one result per active slot, one per cycle while the receiver does not stall,
// rank 0 first, by rotating the chain through its head cell.
// Output channel (o_out_valid / i_out_stall / o_out_res) has a single output
// register; while i_out_stall is high it holds a valid result and the report pauses.
// i_cfg_wr_en writes active_neighbours (0 acts as 1, above MAX_NEIGHBOURS as the max).
// Reset (synchronous, active low) empties the list, zeroes the accumulator and
// sets active_neighbours to 9; the query RAM is not cleared and must be loaded
// before reference pixels are streamed.
module knn_top_k_distance_classifier import knn_pkg::*; #(
    parameter int MAX_NEIGHBOURS = MAX_NEIGHBOURS_DEF,
    parameter int IMAGE_PIXELS   = IMAGE_PIXELS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_request             i_in_req,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_result              o_out_res,
    input  logic                 i_cfg_wr_en,
    input  logic [CNT_CFG_W-1:0] i_cfg_wr_data
);

    `include "knn_top_k_distance_classifier_defines.svh"

    localparam int AW = (IMAGE_PIXELS > 1) ? $clog2(IMAGE_PIXELS) : 1;
    localparam int NW = $clog2(MAX_NEIGHBOURS + 1);

    // configuration
    logic [CNT_CFG_W-1:0] r_active_raw;
    logic [NW-1:0]        w_n_live;

    // input handshake
    logic w_in_acc;
    logic w_in_hit;

    // stage 1: query RAM read
    logic               r_p1_valid;
    logic               r_p1_clear;
    logic               r_p1_hit;
    logic               r_p1_last;
    logic [PIX_W-1:0]   r_p1_pix;
    logic [LABEL_W-1:0] r_p1_label;
    logic [PIX_W-1:0]   w_query_pix;
    logic [PIX_W-1:0]   w_diff;
    logic [2*PIX_W-1:0] w_sq;

    // stage 2: squared difference
    logic               r_p2_valid;
    logic               r_p2_clear;
    logic               r_p2_last;
    logic [2*PIX_W-1:0] r_p2_sq;
    logic [LABEL_W-1:0] r_p2_label;
    logic [DIST_W:0]    w_sum_wide;
    logic [DIST_W-1:0]  w_sum_sat;

    // stage 3: accumulator and chain request
    logic [DIST_W-1:0]  r_sum;
    logic               r_p3_ins;
    logic               r_p3_clear;
    logic [DIST_W-1:0]  r_p3_dist;
    logic [LABEL_W-1:0] r_p3_label;

    // report sequencer and output register
    logic          r_rpt_pend;
    logic [NW-1:0] r_rpt_cnt;
    logic          w_pipe_empty;
    logic          w_out_free;
    logic          w_emit;
    logic          w_rpt_last;
    logic          r_out_valid;
    t_result       r_out_res;

    // chain
    t_chain_ctrl                w_ctrl;
    t_slot [MAX_NEIGHBOURS-1:0] w_slot;
    logic  [MAX_NEIGHBOURS-1:0] w_take;
    logic  [MAX_NEIGHBOURS-1:0] w_active;
    logic  [MAX_NEIGHBOURS-1:0] w_wrap;

    always_comb begin
        priority if (r_active_raw == '0) begin
            w_n_live = NW'(1);
        end else if (32'(r_active_raw) > MAX_NEIGHBOURS) begin
            w_n_live = NW'(MAX_NEIGHBOURS);
        end else begin
            w_n_live = NW'(r_active_raw);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_raw <= ACTIVE_RESET;
        end else if (i_cfg_wr_en) begin
            r_active_raw <= i_cfg_wr_data;
        end
    end

    assign o_in_stall = r_rpt_pend;
    assign w_in_acc   = i_in_valid && !r_rpt_pend;
    assign w_in_hit   = 32'(i_in_req.pixel_index) < IMAGE_PIXELS;

    knn_ram #(
        .WIDTH (PIX_W),
        .DEPTH (IMAGE_PIXELS)
    ) u_query_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_in_acc && (i_in_req.op == OP_LOAD) && w_in_hit),
        .i_wr_addr (AW'(i_in_req.pixel_index)),
        .i_wr_data (i_in_req.pixel_value),
        .i_rd_en   (w_in_acc && (i_in_req.op == OP_REF)),
        .i_rd_addr (AW'(i_in_req.pixel_index)),
        .o_rd_data (w_query_pix)
    );

    // stage 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
        end else begin
            r_p1_valid <= w_in_acc && ((i_in_req.op == OP_REF) || (i_in_req.op == OP_CLEAR));
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_clear <= i_in_req.op == OP_CLEAR;
        r_p1_hit   <= w_in_hit;
        r_p1_last  <= i_in_req.last_pixel;
        r_p1_pix   <= i_in_req.pixel_value;
        r_p1_label <= i_in_req.ref_label;
    end

    assign w_diff = (r_p1_pix > w_query_pix) ? (r_p1_pix - w_query_pix)
                                             : (w_query_pix - r_p1_pix);
    assign w_sq   = r_p1_hit ? ((2*PIX_W)'(w_diff) * (2*PIX_W)'(w_diff)) : '0;

    // stage 2
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_valid <= 1'b0;
        end else begin
            r_p2_valid <= r_p1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p2_clear <= r_p1_clear;
        r_p2_last  <= r_p1_last;
        r_p2_sq    <= w_sq;
        r_p2_label <= r_p1_label;
    end

    assign w_sum_wide = {1'b0, r_sum} + (DIST_W + 1)'(r_p2_sq);
    assign w_sum_sat  = w_sum_wide[DIST_W] ? DIST_MAX : w_sum_wide[DIST_W-1:0];

    // stage 3: accumulate, hand the finished sum to the chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum      <= '0;
            r_p3_ins   <= 1'b0;
            r_p3_clear <= 1'b0;
        end else begin
            r_p3_ins   <= r_p2_valid && !r_p2_clear && r_p2_last;
            r_p3_clear <= r_p2_valid && r_p2_clear;
            if (r_p2_valid && !r_p2_clear) begin
                r_sum <= r_p2_last ? '0 : w_sum_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p3_dist  <= w_sum_sat;
        r_p3_label <= r_p2_label;
    end

    // report sequencer
    assign w_pipe_empty = !r_p1_valid && !r_p2_valid && !r_p3_ins && !r_p3_clear;
    assign w_out_free   = !r_out_valid || !i_out_stall;
    assign w_emit       = r_rpt_pend && w_pipe_empty && w_out_free;
    assign w_rpt_last   = r_rpt_cnt == (w_n_live - NW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rpt_pend  <= 1'b0;
            r_rpt_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_acc && (i_in_req.op == OP_REPORT)) begin
                r_rpt_pend <= 1'b1;
                r_rpt_cnt  <= '0;
            end else if (w_emit) begin
                if (w_rpt_last) begin
                    r_rpt_pend <= 1'b0;
                    r_rpt_cnt  <= '0;
                end else begin
                    r_rpt_cnt <= r_rpt_cnt + NW'(1);
                end
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_res.rank               <= RANK_W'(r_rpt_cnt);
            r_out_res.neighbour_distance <= w_slot[0].valid ? w_slot[0].distance : '0;
            r_out_res.neighbour_label    <= w_slot[0].valid ? w_slot[0].label : '0;
            r_out_res.entry_valid        <= w_slot[0].valid;
            r_out_res.last_entry         <= w_rpt_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out_res;

    // neighbour chain
    assign w_ctrl = '{insert: r_p3_ins, clear: r_p3_clear, rotate: w_emit,
                      distance: r_p3_dist, label: r_p3_label};

    for (genvar i = 0; i < MAX_NEIGHBOURS; i++) begin : g_cell
        assign w_active[i] = NW'(i) < w_n_live;
        assign w_wrap[i]   = NW'(i) == (w_n_live - NW'(1));

        knn_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctrl      (w_ctrl),
            .i_active    (w_active[i]),
            .i_wrap      (w_wrap[i]),
            .i_take_prev ((i == 0) ? 1'b0 : w_take[(i == 0) ? 0 : i - 1]),
            .i_prev      ((i == 0) ? t_slot'('0) : w_slot[(i == 0) ? 0 : i - 1]),
            .i_next      ((i == MAX_NEIGHBOURS - 1) ? t_slot'('0)
                          : w_slot[(i == MAX_NEIGHBOURS - 1) ? i : i + 1]),
            .i_head      (w_slot[0]),
            .o_take      (w_take[i]),
            .o_slot      (w_slot[i])
        );
    end

    `KNN_ASSERT_NOW(a_rotate_excl, w_ctrl.rotate, !w_ctrl.insert && !w_ctrl.clear, "rotate on update")
    `KNN_ASSERT_NOW(a_out_rise, $rose(o_out_valid), $past(r_rpt_pend), "result without report")
    `KNN_ASSERT_NEXT(a_clear_head, w_ctrl.clear, !w_slot[0].valid, "head valid after clear")

endmodule
